// ===== sv/sda_pkg.sv =====
package sda_pkg;

  localparam int unsigned CNT_W     = 11;
  localparam int unsigned INV_W     = 25;
  localparam int unsigned PI_W      = 41;
  localparam int unsigned H_W       = 42;
  localparam int unsigned POLY_W    = 17;
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned MAX_SAMPLES = 1024;

  // register byte addresses
  localparam logic [2:0] REG_SAMPLE_SIZE = 3'd0;
  localparam logic [2:0] REG_INV_DENOM   = 3'd4;

  localparam logic [2:0] CFG_ADDR_W = 3'd3;

endpackage

// ===== sv/site_diversity_accumulator.sv =====
// Site diversity accumulator.
// Input stream (s_axis_*): one transaction per segregating site. tdata holds
// derived_count [10:0] and missing_count [21:11]; tlast holds last_site.
// Output stream (m_axis_*): one transaction per run, sent after the site with
// last_site set. tdata packs theta_pi_sum, thomson_sum, theta_h_sum,
// poly_site_count, theta_w, thomson_valid, bad_site_seen from bit 0 up.
// Configuration goes through the APB port: sample_size at 0x0,
// inv_watterson_denom at 0x4; write only while the block is idle.
// Each polymorphic site runs three restoring divisions on one shared
// divider, one quotient bit per cycle (FRAC_BITS+23 bits each), each
// followed by an accumulate step; a check step comes first, and the next
// site is taken only after the third accumulate step. Other sites pass
// only the check step. After the last site a multiply step registers the
// result. s_axis_tready is low while a site is in work and while a result
// is waiting.
// Reset clears the accumulators, the flags and the registers (sample_size=2,
// inv_watterson_denom=1.0). A stalled receiver holds the result in the output
// register; no site is taken until it is delivered.
module site_diversity_accumulator #(
  parameter int unsigned FRAC_BITS = sda_pkg::FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // derived_count, missing_count
  input  logic         s_axis_tlast,   // last_site
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [183:0] m_axis_tdata,   // pi, thomson, h, poly, theta_w, valid, bad
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned NUM_W = 23;           // 2*k*k fits 23 bits for n up to 2047
  localparam int unsigned DEN_W = 22;           // n*(n-1) fits 22 bits
  localparam int unsigned QW    = NUM_W + FRAC_BITS;
  localparam int unsigned QCW   = $clog2(QW + 1);
  localparam logic [63:0] H_MAX = (64'd1 << sda_pkg::H_W) - 64'd1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV   = 6'b000100,
    S_ACC   = 6'b001000,
    S_MUL   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [10:0] sample_size;
  logic [24:0] inv_denom;
  logic [10:0] d, m;
  logic        last;
  logic [40:0] pi_acc, th_acc;
  logic [41:0] h_acc;
  logic [16:0] poly;
  logic        th_ok, bad;

  // shared divider
  logic [QW-1:0]    dq;
  logic [DEN_W:0]   drem;
  logic [DEN_W-1:0] dden;
  logic [QCW-1:0]   dcnt;
  logic [1:0]       term;
  logic [DEN_W:0]   trial;

  logic [11:0] nsam;
  logic [10:0] n;
  logic [DEN_W-1:0] nn1;

  assign pready = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign nsam = {1'b0, sample_size} - {1'b0, m};
  assign n = nsam[10:0];
  assign nn1 = DEN_W'({11'd0, n} * {11'd0, n - 11'd1});
  assign trial = {drem[DEN_W-1:0], dq[QW-1]} - {1'b0, dden};

  // APB registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_size <= 11'd2;
      inv_denom   <= 25'd16777216;
    end else if (psel && penable && pwrite) begin
      if (paddr == sda_pkg::REG_SAMPLE_SIZE) sample_size <= pwdata[10:0];
      else if (paddr == sda_pkg::REG_INV_DENOM) inv_denom <= pwdata[24:0];
    end
  end

  always_comb begin
    unique case (paddr)
      sda_pkg::REG_SAMPLE_SIZE: prdata = {21'd0, sample_size};
      sda_pkg::REG_INV_DENOM:   prdata = {7'd0, inv_denom};
      default:                  prdata = 32'd0;
    endcase
  end

  // numerator of the current term, shifted up by FRAC_BITS
  function automatic logic [QW-1:0] num_of(input logic [1:0] t, input logic [10:0] k,
                                           input logic [10:0] nv);
    logic [NUM_W-1:0] v;
    logic [NUM_W-1:0] kx;
    begin
      kx = NUM_W'(k);
      unique case (t)
        2'd0:    v = kx;
        2'd1:    v = (kx << 1) * NUM_W'(nv - k);
        default: v = (kx << 1) * kx;
      endcase
      num_of = {v, {FRAC_BITS{1'b0}}};
    end
  endfunction

  function automatic logic [63:0] sat(input logic [63:0] a, input logic [63:0] b,
                                      input logic [63:0] mx);
    begin
      sat = (a > mx || b > mx - a) ? mx : a + b;
    end
  endfunction

  logic [63:0] qv, tw;
  assign qv = 64'(dq);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_axis_tvalid) state_next = S_CHECK;
      S_CHECK: begin
        if (!nsam[11] && nsam != 12'd0 && {1'b0, d} <= nsam && d != 11'd0 &&
            {1'b0, d} != nsam) state_next = S_DIV;
        else state_next = last ? S_MUL : S_IDLE;
      end
      S_DIV:   if (dcnt == QCW'(QW - 1)) state_next = S_ACC;
      S_ACC:   if (term == 2'd2) state_next = last ? S_MUL : S_IDLE;
               else state_next = S_DIV;
      S_MUL:   state_next = S_OUT;
      S_OUT:   if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pi_acc <= '0; th_acc <= '0; h_acc <= '0; poly <= '0;
      th_ok  <= 1'b1; bad <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          d <= s_axis_tdata[10:0];
          m <= s_axis_tdata[21:11];
          last <= s_axis_tlast;
        end
        S_CHECK: begin
          if (nsam[11] || nsam == 12'd0) th_ok <= 1'b0;
          else if ({1'b0, d} > nsam) bad <= 1'b1;
          term <= 2'd0;
          dcnt <= '0;
          drem <= '0;
          dden <= DEN_W'(n);
          dq   <= num_of(2'd0, d, n);
        end
        S_DIV: begin
          // one restoring step per cycle
          dcnt <= dcnt + QCW'(1);
          if (!trial[DEN_W]) begin
            drem <= trial;
            dq   <= {dq[QW-2:0], 1'b1};
          end else begin
            drem <= {drem[DEN_W-1:0], dq[QW-1]};
            dq   <= {dq[QW-2:0], 1'b0};
          end
        end
        S_ACC: begin
          unique case (term)
            2'd0: th_acc <= 41'(sat(64'(th_acc), qv > H_MAX ? H_MAX : qv,
                                    64'(41'h1FFFFFFFFFF)));
            2'd1: pi_acc <= 41'(sat(64'(pi_acc), qv > H_MAX ? H_MAX : qv,
                                    64'(41'h1FFFFFFFFFF)));
            default: begin
              h_acc <= 42'(sat(64'(h_acc), qv > H_MAX ? H_MAX : qv, H_MAX));
              if (poly != '1) poly <= poly + 17'd1;
            end
          endcase
          term <= term + 2'd1;
          dcnt <= '0;
          drem <= '0;
          dden <= nn1;
          dq   <= num_of(term + 2'd1, d, n);
        end
        S_MUL: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= {bad, th_ok,
                            (tw > 64'h1FFFFFFFFFF) ? 41'h1FFFFFFFFFF : tw[40:0],
                            poly, h_acc, th_ok ? th_acc : 41'd0, pi_acc};
          pi_acc <= '0; th_acc <= '0; h_acc <= '0; poly <= '0;
          th_ok <= 1'b1; bad <= 1'b0;
        end
        S_OUT: if (m_axis_tready) m_axis_tvalid <= 1'b0;
        default: ;
      endcase
    end
  end

  assign tw = 64'(poly) * 64'(inv_denom);

  // the divider only runs on a polymorphic site
  assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dden != '0) else $error("divide by zero");
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> state == S_OUT) else $error("result outside output state");
  assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |=> m_axis_tvalid && poly == '0) else $error("run not cleared");

endmodule
